@@ design/pfs_pkg.sv @@
package pfs_pkg;

  // Field widths
  localparam int unsigned CRYSTAL_W   = 26;
  localparam int unsigned TARGET_W    = 32;
  localparam int unsigned VIN_CFG_W   = 22;
  localparam int unsigned VOUT_CFG_W  = 29;
  localparam int unsigned STEP_W      = 26;
  localparam int unsigned CFG_DATA_W  = 29;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PRE_W       = 6;
  localparam int unsigned MUL_W       = 9;
  localparam int unsigned POST_W      = 4;
  localparam int unsigned HZ_W        = 28;
  localparam int unsigned SLOW_W      = 26;
  localparam int unsigned FAST_W      = 27;
  localparam int unsigned WAIT_W      = 3;

  // Search bounds
  localparam int unsigned PRE_DIV_MIN  = 2;
  localparam int unsigned PRE_DIV_MAX  = 63;
  localparam int unsigned MUL_MIN      = 64;
  localparam int unsigned MUL_MAX      = 432;
  localparam int unsigned POST_DIV_MAX = 8;
  localparam int unsigned POST_CNT     = POST_DIV_MAX / 2;
  localparam int unsigned POST_IDX_W   = $clog2(POST_CNT);
  localparam int unsigned SIX_DIV      = 6;

  // Internal datapath widths
  localparam int unsigned VIN_W   = 25;  // crystal / 2 at most
  localparam int unsigned VOUT_W  = 34;  // VCO input times largest multiplier
  localparam int unsigned CORE_W  = 33;  // VCO output / 2
  localparam int unsigned A_W     = 23;  // VCO input / 6
  localparam int unsigned Q6_W    = 32;  // VCO output / 6
  localparam int unsigned R6_W    = 3;

  // Shared divider
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 26;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Register reset values
  localparam logic [VIN_CFG_W-1:0]  VCO_IN_MIN_RST  = VIN_CFG_W'(1000000);
  localparam logic [VIN_CFG_W-1:0]  VCO_IN_MAX_RST  = VIN_CFG_W'(2000000);
  localparam logic [VOUT_CFG_W-1:0] VCO_OUT_MIN_RST = VOUT_CFG_W'(64000000);
  localparam logic [VOUT_CFG_W-1:0] VCO_OUT_MAX_RST = VOUT_CFG_W'(432000000);
  localparam logic [STEP_W-1:0]     FLASH_STEP_RST  = STEP_W'(30000000);

  localparam logic [WAIT_W-1:0] WAIT_ZERO_STEP = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VCO_IN_MIN  = 3'd0,
    CFG_VCO_IN_MAX  = 3'd1,
    CFG_VCO_OUT_MIN = 3'd2,
    CFG_VCO_OUT_MAX = 3'd3,
    CFG_FLASH_STEP  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [VIN_CFG_W-1:0]  vco_in_min_hz;
    logic [VIN_CFG_W-1:0]  vco_in_max_hz;
    logic [VOUT_CFG_W-1:0] vco_out_min_hz;
    logic [VOUT_CFG_W-1:0] vco_out_max_hz;
    logic [STEP_W-1:0]     flash_step_hz;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic [PRE_W-1:0]  pre_divider;
    logic [MUL_W-1:0]  multiplier;
    logic [POST_W-1:0] post_divider;
    logic [HZ_W-1:0]   achieved_hz;
    logic [SLOW_W-1:0] slow_bus_hz;
    logic [FAST_W-1:0] fast_bus_hz;
    logic              exact_match;
    logic [WAIT_W-1:0] flash_wait;
  } out_item_t;

  // Quotient of (rem * MUL_MIN) / 6 for a remainder of a division by six
  function automatic logic [Q6_W-1:0] six_quot(input logic [R6_W-1:0] rem);
    logic [Q6_W-1:0] res;
    case (rem)
      3'd1:    res = Q6_W'((1 * MUL_MIN) / SIX_DIV);
      3'd2:    res = Q6_W'((2 * MUL_MIN) / SIX_DIV);
      3'd3:    res = Q6_W'((3 * MUL_MIN) / SIX_DIV);
      3'd4:    res = Q6_W'((4 * MUL_MIN) / SIX_DIV);
      3'd5:    res = Q6_W'((5 * MUL_MIN) / SIX_DIV);
      default: res = '0;
    endcase
    return res;
  endfunction

  // Remainder of (rem * MUL_MIN) / 6
  function automatic logic [R6_W-1:0] six_rem(input logic [R6_W-1:0] rem);
    logic [R6_W-1:0] res;
    case (rem)
      3'd1:    res = R6_W'((1 * MUL_MIN) % SIX_DIV);
      3'd2:    res = R6_W'((2 * MUL_MIN) % SIX_DIV);
      3'd3:    res = R6_W'((3 * MUL_MIN) % SIX_DIV);
      3'd4:    res = R6_W'((4 * MUL_MIN) % SIX_DIV);
      3'd5:    res = R6_W'((5 * MUL_MIN) % SIX_DIV);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ design/pfs_chan_if.sv @@
interface pfs_in_if import pfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CRYSTAL_W-1:0] crystal_hz;
  logic [TARGET_W-1:0]  target_hz;

  modport source (output valid, output crystal_hz, output target_hz, input ready);
  modport sink   (input valid, input crystal_hz, input target_hz, output ready);
endinterface

interface pfs_out_if import pfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRE_W-1:0]  pre_divider;
  logic [MUL_W-1:0]  multiplier;
  logic [POST_W-1:0] post_divider;
  logic [HZ_W-1:0]   achieved_hz;
  logic [SLOW_W-1:0] slow_bus_hz;
  logic [FAST_W-1:0] fast_bus_hz;
  logic              exact_match;
  logic [WAIT_W-1:0] flash_wait;

  modport source (output valid, output pre_divider, output multiplier, output post_divider,
                  output achieved_hz, output slow_bus_hz, output fast_bus_hz,
                  output exact_match, output flash_wait, input ready);
  modport sink   (input valid, input pre_divider, input multiplier, input post_divider,
                  input achieved_hz, input slow_bus_hz, input fast_bus_hz,
                  input exact_match, input flash_wait, output ready);
endinterface

@@ design/pfs_divider.sv @@
module pfs_divider import pfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ design/pfs_seq.sv @@
module pfs_seq import pfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 start_i,
  input  logic [CRYSTAL_W-1:0] crystal_i,
  input  logic [TARGET_W-1:0]  target_i,
  output logic                 idle_o,
  output div_req_t             div_req_o,
  input  div_rsp_t             div_rsp_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output out_item_t            res_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIV_VIN  = 6'b000010,
    S_DIV_SIX  = 6'b000100,
    S_POST     = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CRYSTAL_W-1:0]  crystal_q, crystal_d;
  logic [TARGET_W-1:0]   target_q, target_d;
  logic [PRE_W-1:0]      pre_q, pre_d;
  logic [MUL_W-1:0]      mul_q, mul_d;
  logic [POST_IDX_W-1:0] post_q, post_d;
  logic [VIN_W-1:0]      vin_q, vin_d;
  logic [A_W-1:0]        a_q, a_d;
  logic [R6_W-1:0]       b_q, b_d;
  logic [VOUT_W-1:0]     vout_q, vout_d;
  logic [Q6_W-1:0]       q6_q, q6_d;
  logic [R6_W-1:0]       r6_q, r6_d;
  logic [HZ_W-1:0]       best_hz_q, best_hz_d;
  logic [PRE_W-1:0]      best_pre_q, best_pre_d;
  logic [MUL_W-1:0]      win_mul_q, win_mul_d;
  logic [POST_W-1:0]     best_post_q, best_post_d;
  logic [WAIT_W-1:0]     wait_q, wait_d;

  logic [VIN_W-1:0]      quot_vin;
  logic                  vin_ok;
  logic                  vout_ok;
  logic                  pre_last;
  logic                  mul_last;
  logic                  post_last;
  logic [CORE_W-1:0]     core;
  logic [POST_W-1:0]     post_val;
  logic                  cand_ok;
  logic [R6_W:0]         r_sum;
  logic                  r_wrap;
  logic [PRE_W-1:0]      pre_next;

  // Window checks and the core frequency for the current post-divider
  always_comb begin
    quot_vin  = div_rsp_i.quotient[VIN_W-1:0];
    vin_ok    = (quot_vin >= VIN_W'(cfg_i.vco_in_min_hz)) &&
                (quot_vin <= VIN_W'(cfg_i.vco_in_max_hz));
    vout_ok   = (vout_q >= VOUT_W'(cfg_i.vco_out_min_hz)) &&
                (vout_q <= VOUT_W'(cfg_i.vco_out_max_hz));
    pre_last  = pre_q == PRE_W'(PRE_DIV_MAX);
    mul_last  = mul_q == MUL_W'(MUL_MAX);
    post_last = post_q == POST_IDX_W'(POST_CNT - 1);
    pre_next  = pre_q + 1'b1;
    post_val  = POST_W'({post_q, 1'b0}) + POST_W'(2);
    case (post_q)
      2'd0:    core = CORE_W'(vout_q >> 1);
      2'd1:    core = CORE_W'(vout_q >> 2);
      2'd2:    core = CORE_W'(q6_q);
      default: core = CORE_W'(vout_q >> 3);
    endcase
    cand_ok = vout_ok && (core <= CORE_W'(target_q)) && (core > CORE_W'(best_hz_q));
    r_sum   = {1'b0, r6_q} + {1'b0, b_q};
    r_wrap  = r_sum >= (R6_W + 1)'(SIX_DIV);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    crystal_d   = crystal_q;
    target_d    = target_q;
    pre_d       = pre_q;
    mul_d       = mul_q;
    post_d      = post_q;
    vin_d       = vin_q;
    a_d         = a_q;
    b_d         = b_q;
    vout_d      = vout_q;
    q6_d        = q6_q;
    r6_d        = r6_q;
    best_hz_d   = best_hz_q;
    best_pre_d  = best_pre_q;
    win_mul_d   = win_mul_q;
    best_post_d = best_post_q;
    wait_d      = wait_q;
    div_req_o   = '{start: 1'b0, dividend: DIVIDEND_W'(crystal_q),
                    divisor: DIVISOR_W'(pre_next)};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          crystal_d   = crystal_i;
          target_d    = target_i;
          pre_d       = PRE_W'(PRE_DIV_MIN);
          best_hz_d   = '0;
          best_pre_d  = '0;
          win_mul_d   = '0;
          best_post_d = '0;
          div_req_o   = '{start: 1'b1, dividend: DIVIDEND_W'(crystal_i),
                          divisor: DIVISOR_W'(PRE_DIV_MIN)};
          state_d     = S_DIV_VIN;
        end
      end

      S_DIV_VIN: begin
        if (div_rsp_i.done) begin
          vin_d = quot_vin;
          if (vin_ok) begin
            div_req_o = '{start: 1'b1, dividend: DIVIDEND_W'(quot_vin),
                          divisor: DIVISOR_W'(SIX_DIV)};
            state_d   = S_DIV_SIX;
          end else if (pre_last) begin
            div_req_o = '{start: 1'b1, dividend: DIVIDEND_W'(target_q),
                          divisor: DIVISOR_W'(cfg_i.flash_step_hz)};
            state_d   = S_DIV_WAIT;
          end else begin
            div_req_o.start = 1'b1;
            pre_d           = pre_next;
          end
        end
      end

      // Seed the multiplier sweep: VCO output and its split by six
      S_DIV_SIX: begin
        if (div_rsp_i.done) begin
          a_d     = div_rsp_i.quotient[A_W-1:0];
          b_d     = div_rsp_i.remainder[R6_W-1:0];
          vout_d  = VOUT_W'(vin_q) * VOUT_W'(MUL_MIN);
          q6_d    = Q6_W'(div_rsp_i.quotient[A_W-1:0]) * Q6_W'(MUL_MIN) +
                    six_quot(div_rsp_i.remainder[R6_W-1:0]);
          r6_d    = six_rem(div_rsp_i.remainder[R6_W-1:0]);
          mul_d   = MUL_W'(MUL_MIN);
          post_d  = '0;
          state_d = S_POST;
        end
      end

      // Try one post-divider per cycle
      S_POST: begin
        if (cand_ok) begin
          best_hz_d   = core[HZ_W-1:0];
          best_pre_d  = pre_q;
          win_mul_d   = mul_q;
          best_post_d = post_val;
        end
        post_d = post_q + 1'b1;
        if (post_last) begin
          if (!mul_last) begin
            mul_d  = mul_q + 1'b1;
            vout_d = vout_q + VOUT_W'(vin_q);
            if (r_wrap) begin
              r6_d = R6_W'(r_sum - (R6_W + 1)'(SIX_DIV));
              q6_d = q6_q + Q6_W'(a_q) + Q6_W'(1);
            end else begin
              r6_d = r_sum[R6_W-1:0];
              q6_d = q6_q + Q6_W'(a_q);
            end
          end else if (pre_last) begin
            div_req_o = '{start: 1'b1, dividend: DIVIDEND_W'(target_q),
                          divisor: DIVISOR_W'(cfg_i.flash_step_hz)};
            state_d   = S_DIV_WAIT;
          end else begin
            div_req_o.start = 1'b1;
            pre_d           = pre_next;
            state_d         = S_DIV_VIN;
          end
        end
      end

      S_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          wait_d  = (cfg_i.flash_step_hz == '0) ? WAIT_ZERO_STEP
                                                : div_rsp_i.quotient[WAIT_W-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crystal_q   <= crystal_d;
    target_q    <= target_d;
    pre_q       <= pre_d;
    mul_q       <= mul_d;
    post_q      <= post_d;
    vin_q       <= vin_d;
    a_q         <= a_d;
    b_q         <= b_d;
    vout_q      <= vout_d;
    q6_q        <= q6_d;
    r6_q        <= r6_d;
    best_hz_q   <= best_hz_d;
    best_pre_q  <= best_pre_d;
    win_mul_q   <= win_mul_d;
    best_post_q <= best_post_d;
    wait_q      <= wait_d;
  end

  // Result beat
  assign idle_o      = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;

  always_comb begin
    res_o.pre_divider  = best_pre_q;
    res_o.multiplier   = win_mul_q;
    res_o.post_divider = best_post_q;
    res_o.achieved_hz  = best_hz_q;
    res_o.slow_bus_hz  = best_hz_q[HZ_W-1:2];
    res_o.fast_bus_hz  = best_hz_q[HZ_W-1:1];
    res_o.exact_match  = TARGET_W'(best_hz_q) == target_q;
    res_o.flash_wait   = wait_q;
  end

endmodule

@@ design/pll_factor_search.sv @@
// PLL factor search.
// Input channel in_i carries one beat per request: crystal frequency and
// target core frequency. Output channel out_o returns one beat per request:
// pre-divider, multiplier, post-divider, achieved core and bus clocks, an
// exact-match flag and flash wait states. The user must write registers
// through cfg_we_i / cfg_idx_i / cfg_data_i only while no request is in
// flight; the block itself does not enforce this. For each pre-divider the
// request runs one division for the VCO input; a pre-divider whose VCO input
// passes the window adds a division by six and a sweep of every multiplier
// with every post-divider. The wait-state division and the load of the
// output register follow. The time is set by the shared 32-step serial
// divider and by the post-divider check, which looks at one candidate per
// cycle. in_i.ready is high only while the search engine is idle, so one
// request is in the engine at a time. The result sits in an output
// register; the engine returns to idle as soon as that register is free, so
// a new request may be taken while the receiver stalls on the previous
// result. Reset clears all control state and loads the register defaults;
// a request can be taken at the first clock edge after reset release.
module pll_factor_search import pfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pfs_in_if.sink                in_i,
  pfs_out_if.source             out_o
);

  cfg_t      cfg_q, cfg_d;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      seq_idle;
  logic      seq_res_valid;
  logic      out_room;
  out_item_t seq_res;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VCO_IN_MIN:  cfg_d.vco_in_min_hz  = cfg_data_i[VIN_CFG_W-1:0];
        CFG_VCO_IN_MAX:  cfg_d.vco_in_max_hz  = cfg_data_i[VIN_CFG_W-1:0];
        CFG_VCO_OUT_MIN: cfg_d.vco_out_min_hz = cfg_data_i[VOUT_CFG_W-1:0];
        CFG_VCO_OUT_MAX: cfg_d.vco_out_max_hz = cfg_data_i[VOUT_CFG_W-1:0];
        CFG_FLASH_STEP:  cfg_d.flash_step_hz  = cfg_data_i[STEP_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vco_in_min_hz  <= VCO_IN_MIN_RST;
      cfg_q.vco_in_max_hz  <= VCO_IN_MAX_RST;
      cfg_q.vco_out_min_hz <= VCO_OUT_MIN_RST;
      cfg_q.vco_out_max_hz <= VCO_OUT_MAX_RST;
      cfg_q.flash_step_hz  <= FLASH_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Search engine and shared divider
  pfs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pfs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_i.valid && seq_idle),
    .crystal_i   (in_i.crystal_hz),
    .target_i    (in_i.target_hz),
    .idle_o      (seq_idle),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_valid_o (seq_res_valid),
    .res_ready_i (out_room),
    .res_o       (seq_res)
  );

  assign in_i.ready = seq_idle;

  // Output register: load when empty or being drained
  assign out_room = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_room) begin
      out_valid_d = seq_res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_room && seq_res_valid) begin
      out_q <= seq_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pre_divider  = out_q.pre_divider;
  assign out_o.multiplier   = out_q.multiplier;
  assign out_o.post_divider = out_q.post_divider;
  assign out_o.achieved_hz  = out_q.achieved_hz;
  assign out_o.slow_bus_hz  = out_q.slow_bus_hz;
  assign out_o.fast_bus_hz  = out_q.fast_bus_hz;
  assign out_o.exact_match  = out_q.exact_match;
  assign out_o.flash_wait   = out_q.flash_wait;

`ifndef SYNTHESIS
  // An accepted request makes the engine busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("engine still ready after accepting a request");

  // No winner means all factors and frequencies are zero
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pre_divider == '0 |->
      out_q.achieved_hz == '0 && out_q.post_divider == '0 && out_q.multiplier == '0)
    else $error("partial result without a winning pre-divider");

  // A winner carries a multiplier of at least MUL_MIN and a post-divider
  a_winner_factors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pre_divider != '0 |->
      out_q.multiplier >= MUL_W'(MUL_MIN) && out_q.post_divider != '0)
    else $error("winning candidate with out-of-range factors");
`endif

endmodule
